// File: hw/rtl/assert_macros.svh
// assertion macros used by white_blob_steering_unit.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/wbs_pkg.sv
// constants and codes for the white blob steering unit
`timescale 1ns / 1ps

package wbs_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_WHITE_LEVEL   = 3'd2;
    localparam logic [2:0] CFG_FORWARD_SPEED = 3'd3;
    localparam logic [2:0] CFG_TURN_SPEED    = 3'd4;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 15;
    localparam int SIZE_BITS     = 13;
    localparam int LEVEL_BITS    = 8;
    localparam int SPEED_BITS    = 15;
    localparam int VEL_BITS      = 16;
    localparam int CHAN_BITS     = 8;

    // register reset values
    localparam logic [SIZE_BITS-1:0]  RST_FRAME_WIDTH  = 13'd640;
    localparam logic [SIZE_BITS-1:0]  RST_FRAME_HEIGHT = 13'd480;
    localparam logic [LEVEL_BITS-1:0] RST_WHITE_LEVEL  = 8'd255;
    localparam logic [SPEED_BITS-1:0] RST_FORWARD      = 15'd410;
    localparam logic [SPEED_BITS-1:0] RST_TURN         = 15'd410;

    // steering codes
    localparam logic [1:0] DIR_STOP    = 2'd0;
    localparam logic [1:0] DIR_LEFT    = 2'd1;
    localparam logic [1:0] DIR_FORWARD = 2'd2;
    localparam logic [1:0] DIR_RIGHT   = 2'd3;

    // floor(n / 3) as (n * THIRD_RECIP) >> THIRD_SHIFT, exact for n below 2^16
    localparam logic [15:0] THIRD_RECIP = 16'd43691;
    localparam int          THIRD_SHIFT = 17;

endpackage

// File: hw/rtl/white_blob_steering_unit.sv
// white blob steering unit: bounding box of white pixels and steering choice
`timescale 1ns / 1ps
`include "assert_macros.svh"

// White blob steering unit.
// Input stream s_*: one RGB pixel per beat in raster order, s_tdata holds
// red, green, blue from the lowest byte up. The unit counts column and row
// itself from the frame_width and frame_height registers and tracks the
// bounding box of pixels whose three channels all equal white_level.
// Output stream m_*: one beat per frame, produced after the last pixel of
// the frame: found flag, box centre, direction code and Q3.12 velocities.
// Throughput: one pixel per cycle while s_tready is high, set by the
// combinational compare and min/max update of the box registers.
// Result path: the edge that accepts the last pixel of a frame loads the
// box close stage; the centre and steering stage then loads the output
// register that drives m_tvalid as soon as that register is free.
// When the receiver stalls, the result waits in the output register and the
// closed box waits in the stage before it; pixels keep flowing until both
// are full, then s_tready drops until m_tready takes the waiting beat.
// Configuration: plain write port cfg_we/cfg_addr/cfg_wdata; the user must
// write only while the unit is idle (not enforced); unknown indexes are ignored.
// Reset (aresetn low at a clock edge): registers go to their default values,
// counters and box start a fresh frame, both streams come up empty.
module white_blob_steering_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [wbs_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [wbs_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    // pixel stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // fields from bit 0 up: red[7:0], green[7:0], blue[7:0]
    input  logic [23:0]                       s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // fields from bit 0 up: blob_found, center_row, center_col, direction,
    // linear_vel, turn_rate, then zero fill
    output logic [((2*COORD_BITS+35+7)/8)*8-1:0] m_tdata
);

    localparam int SB       = wbs_pkg::SIZE_BITS;
    localparam int CW       = (COORD_BITS > SB) ? COORD_BITS : SB;
    localparam int OUT_USED = 2*COORD_BITS + 35;
    localparam int OUT_BITS = ((OUT_USED + 7) / 8) * 8;
    localparam logic [16:0] COORD_LIMIT = 17'd1 << COORD_BITS;
    localparam int PROD_BITS = SB + 16;

    // configuration registers
    logic [SB-1:0]                      frame_width_reg;
    logic [SB-1:0]                      frame_height_reg;
    logic [wbs_pkg::LEVEL_BITS-1:0]     white_level_reg;
    logic [wbs_pkg::SPEED_BITS-1:0]     forward_speed_reg;
    logic [wbs_pkg::SPEED_BITS-1:0]     turn_speed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= wbs_pkg::RST_FRAME_WIDTH;
            frame_height_reg  <= wbs_pkg::RST_FRAME_HEIGHT;
            white_level_reg   <= wbs_pkg::RST_WHITE_LEVEL;
            forward_speed_reg <= wbs_pkg::RST_FORWARD;
            turn_speed_reg    <= wbs_pkg::RST_TURN;
        end else if (cfg_we) begin
            case (cfg_addr)
                wbs_pkg::CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_wdata[SB-1:0];
                wbs_pkg::CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_wdata[SB-1:0];
                wbs_pkg::CFG_WHITE_LEVEL:
                    white_level_reg <= cfg_wdata[wbs_pkg::LEVEL_BITS-1:0];
                wbs_pkg::CFG_FORWARD_SPEED: forward_speed_reg <= cfg_wdata;
                wbs_pkg::CFG_TURN_SPEED:    turn_speed_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective frame size: zero reads as one, saturated to the coordinate range
    logic [SB-1:0] eff_width;
    logic [SB-1:0] eff_height;
    logic [SB-1:0] last_col;
    logic [SB-1:0] last_row;

    always_comb begin
        if (frame_width_reg == '0) begin
            eff_width = SB'(1);
        end else if (17'(frame_width_reg) > COORD_LIMIT) begin
            eff_width = SB'(COORD_LIMIT);
        end else begin
            eff_width = frame_width_reg;
        end
        if (frame_height_reg == '0) begin
            eff_height = SB'(1);
        end else if (17'(frame_height_reg) > COORD_LIMIT) begin
            eff_height = SB'(COORD_LIMIT);
        end else begin
            eff_height = frame_height_reg;
        end
        last_col = eff_width - SB'(1);
        last_row = eff_height - SB'(1);
    end

    // thirds of the width, registered off the static configuration
    logic [PROD_BITS-1:0] third_prod;
    logic [SB-1:0]        third_reg;
    logic [SB-1:0]        upper_reg;

    assign third_prod = PROD_BITS'(eff_width) * PROD_BITS'(wbs_pkg::THIRD_RECIP);

    always_ff @(posedge aclk) begin
        third_reg <= SB'(third_prod >> wbs_pkg::THIRD_SHIFT);
        upper_reg <= eff_width - SB'(third_prod >> wbs_pkg::THIRD_SHIFT);
    end

    // handshake state
    logic done_valid_reg;
    logic m_tvalid_reg;
    logic out_free;
    logic done_move;
    logic s_accept;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign done_move = done_valid_reg && out_free;
    assign s_tready  = !done_valid_reg || out_free;
    assign s_accept  = s_tvalid && s_tready;

    // pixel classification and raster position
    logic [COORD_BITS-1:0] col_count_reg;
    logic [COORD_BITS-1:0] row_count_reg;
    logic                  any_white_reg;
    logic [COORD_BITS-1:0] row_low_reg;
    logic [COORD_BITS-1:0] row_high_reg;
    logic [COORD_BITS-1:0] col_low_reg;
    logic [COORD_BITS-1:0] col_high_reg;

    logic                  is_white;
    logic                  row_end;
    logic                  frame_end;
    logic                  any_white_next;
    logic [COORD_BITS-1:0] row_low_next;
    logic [COORD_BITS-1:0] row_high_next;
    logic [COORD_BITS-1:0] col_low_next;
    logic [COORD_BITS-1:0] col_high_next;

    assign is_white = (s_tdata[7:0]   == white_level_reg) &&
                      (s_tdata[15:8]  == white_level_reg) &&
                      (s_tdata[23:16] == white_level_reg);

    assign row_end   = CW'(col_count_reg) >= CW'(last_col);
    assign frame_end = row_end && (CW'(row_count_reg) >= CW'(last_row));

    // box bounds including the current pixel, each bound on its own
    always_comb begin
        any_white_next = any_white_reg;
        row_low_next   = row_low_reg;
        row_high_next  = row_high_reg;
        col_low_next   = col_low_reg;
        col_high_next  = col_high_reg;
        if (is_white) begin
            any_white_next = 1'b1;
            if (row_count_reg < row_low_reg)  row_low_next  = row_count_reg;
            if (row_count_reg > row_high_reg) row_high_next = row_count_reg;
            if (col_count_reg < col_low_reg)  col_low_next  = col_count_reg;
            if (col_count_reg > col_high_reg) col_high_next = col_count_reg;
        end
    end

    // counters and box registers, reloaded at frame end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            any_white_reg <= 1'b0;
            row_low_reg   <= '1;
            row_high_reg  <= '0;
            col_low_reg   <= '1;
            col_high_reg  <= '0;
        end else if (s_accept) begin
            if (frame_end) begin
                col_count_reg <= '0;
                row_count_reg <= '0;
                any_white_reg <= 1'b0;
                row_low_reg   <= '1;
                row_high_reg  <= '0;
                col_low_reg   <= '1;
                col_high_reg  <= '0;
            end else begin
                if (row_end) begin
                    col_count_reg <= '0;
                    row_count_reg <= row_count_reg + COORD_BITS'(1);
                end else begin
                    col_count_reg <= col_count_reg + COORD_BITS'(1);
                end
                any_white_reg <= any_white_next;
                row_low_reg   <= row_low_next;
                row_high_reg  <= row_high_next;
                col_low_reg   <= col_low_next;
                col_high_reg  <= col_high_next;
            end
        end
    end

    // closed box stage
    logic                  done_found_reg;
    logic [COORD_BITS-1:0] done_row_low_reg;
    logic [COORD_BITS-1:0] done_row_high_reg;
    logic [COORD_BITS-1:0] done_col_low_reg;
    logic [COORD_BITS-1:0] done_col_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_valid_reg <= 1'b0;
        end else if (s_accept && frame_end) begin
            done_valid_reg <= 1'b1;
        end else if (done_move) begin
            done_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && frame_end) begin
            done_found_reg    <= any_white_next;
            done_row_low_reg  <= row_low_next;
            done_row_high_reg <= row_high_next;
            done_col_low_reg  <= col_low_next;
            done_col_high_reg <= col_high_next;
        end
    end

    // centre and steering choice
    logic [COORD_BITS:0]   row_sum;
    logic [COORD_BITS:0]   col_sum;
    logic [COORD_BITS-1:0] center_row_next;
    logic [COORD_BITS-1:0] center_col_next;
    logic [1:0]            direction_next;
    logic [wbs_pkg::VEL_BITS-1:0] linear_next;
    logic [wbs_pkg::VEL_BITS-1:0] angular_next;

    assign row_sum = {1'b0, done_row_low_reg} + {1'b0, done_row_high_reg};
    assign col_sum = {1'b0, done_col_low_reg} + {1'b0, done_col_high_reg};

    always_comb begin
        center_row_next = '0;
        center_col_next = '0;
        direction_next  = wbs_pkg::DIR_STOP;
        linear_next     = '0;
        angular_next    = '0;
        if (done_found_reg) begin
            center_row_next = row_sum[COORD_BITS:1];
            center_col_next = col_sum[COORD_BITS:1];
            if (CW'(col_sum[COORD_BITS:1]) < CW'(third_reg)) begin
                direction_next = wbs_pkg::DIR_LEFT;
                angular_next   = {1'b0, turn_speed_reg};
            end else if (CW'(col_sum[COORD_BITS:1]) < CW'(upper_reg)) begin
                direction_next = wbs_pkg::DIR_FORWARD;
                linear_next    = {1'b0, forward_speed_reg};
            end else begin
                direction_next = wbs_pkg::DIR_RIGHT;
                angular_next   = wbs_pkg::VEL_BITS'(0) - {1'b0, turn_speed_reg};
            end
        end
    end

    // result register
    logic                  out_found_reg;
    logic [COORD_BITS-1:0] out_row_reg;
    logic [COORD_BITS-1:0] out_col_reg;
    logic [1:0]            out_dir_reg;
    logic [wbs_pkg::VEL_BITS-1:0] out_lin_reg;
    logic [wbs_pkg::VEL_BITS-1:0] out_ang_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= done_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_move) begin
            out_found_reg <= done_found_reg;
            out_row_reg   <= center_row_next;
            out_col_reg   <= center_col_next;
            out_dir_reg   <= direction_next;
            out_lin_reg   <= linear_next;
            out_ang_reg   <= angular_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_BITS'({out_ang_reg, out_lin_reg, out_dir_reg,
                                 out_col_reg, out_row_reg, out_found_reg});

    // checks
    logic out_is_idle;
    logic out_is_fwd;

    assign out_is_idle = (out_dir_reg == wbs_pkg::DIR_STOP) && (out_lin_reg == '0) &&
                         (out_ang_reg == '0);
    assign out_is_fwd  = m_tvalid_reg && (out_dir_reg == wbs_pkg::DIR_FORWARD);

    `ASSERT_NEXT(a_frame_end_closes_box, aclk, aresetn, s_accept && frame_end, done_valid_reg)
    `ASSERT_NEXT(a_box_reaches_output, aclk, aresetn, done_move, m_tvalid)
    `ASSERT_IMPLIES(a_empty_frame_stops, aclk, aresetn, m_tvalid_reg && !out_found_reg, out_is_idle)
    `ASSERT_IMPLIES(a_forward_no_turn, aclk, aresetn, out_is_fwd, out_ang_reg == '0)

endmodule
